// ===== hw/rtl/aec_pkg.sv =====
package aec_pkg;

    // fixed geometry of the comparison word
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = WORD_BYTES * 8;

    // configuration registers
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK_LENGTH = 1'b1;
    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET    = 24'd4768;
    localparam logic [CFG_W-1:0] MAX_CHUNK_LENGTH_RESET = 24'd65536;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_buffer;
    } in_t;

    typedef struct packed {
        logic [31:0] chunk_length;
        logic        final_chunk;
    } out_t;

    // results produced by one request, in order
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } push_t;

endpackage

// ===== hw/rtl/asymmetric_extremum_chunker_unit.sv =====
// asymmetric extremum content-defined chunker: takes a byte stream one byte per
// request and returns chunk lengths; each position's value is the 8-byte
// little-endian word starting there, a word not above the running extreme
// replaces it, and a greater word cuts the chunk at window_length past the
// extreme or at max_chunk_length; the buffer's last byte flushes the rest as a
// final chunk. throughput is one byte per cycle while the result queue has room,
// set by the state update between the input register and the result queue. an
// accepted byte waits in the input register until its results enter the queue
// and show on m_valid. a byte that cuts on the buffer's last byte yields two
// results; the 4-entry result queue absorbs them and the input stalls only
// while fewer than two queue entries are free. the user must write registers
// through cfg_we/cfg_index/cfg_data with the block idle; it does not enforce this.
module asymmetric_extremum_chunker_unit #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // byte stream
    input  logic                             s_valid,
    output logic                             s_ready,
    input  aec_pkg::in_t                     s_data,
    // chunk lengths
    output logic                             m_valid,
    input  logic                             m_ready,
    output aec_pkg::out_t                    m_data,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [aec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aec_pkg::CFG_W-1:0]        cfg_data
);

    aec_pkg::push_t push;
    logic           push_space;

    // input register, extreme tracking and cut decision
    aec_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_space (push_space),
        .push       (push)
    );

    // result queue, up to two writes per cycle, one read
    aec_result_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_space (push_space),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== hw/rtl/aec_core.sv =====
module aec_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  aec_pkg::in_t                        s_data,
    input  logic                                cfg_we,
    input  logic [aec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aec_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                push_space,
    output aec_pkg::push_t                      push
);

    localparam int CNT_W = (LENGTH_BITS >= 32) ? 32 : LENGTH_BITS;
    localparam int SUM_W = ((CNT_W > aec_pkg::CFG_W) ? CNT_W : aec_pkg::CFG_W) + 1;

    logic                       in_vld_reg;
    aec_pkg::in_t               in_reg;
    logic [aec_pkg::CFG_W-1:0]  wl_reg;
    logic [aec_pkg::CFG_W-1:0]  mcl_reg;

    logic [aec_pkg::WORD_W-1:0] rb_reg, rb_next;
    logic [3:0]                 fc_reg, fc_next;
    logic [aec_pkg::WORD_W-1:0] ext_reg, ext_next;
    logic [CNT_W-1:0]           eo_reg, eo_next;
    logic [CNT_W-1:0]           co_reg, co_next;

    logic                       fire;
    logic                       last;
    logic [aec_pkg::WORD_W-1:0] word;
    logic [3:0]                 fc_inc;
    logic [CNT_W-1:0]           co_inc;
    logic [CNT_W-1:0]           pos;
    logic [CNT_W-1:0]           tail_len;
    logic                       word_ok;
    logic                       pos_zero;
    logic                       not_greater;
    logic                       at_window;
    logic                       at_max;
    logic                       in_window;
    logic                       cut;

    assign fire    = in_vld_reg && push_space;
    assign s_ready = !in_vld_reg || fire;
    assign last    = in_reg.last_of_buffer;

    always_comb begin
        word        = {in_reg.data_byte, rb_reg[aec_pkg::WORD_W-1:8]};
        fc_inc      = (fc_reg < 4'(aec_pkg::WORD_BYTES)) ? fc_reg + 4'd1 : fc_reg;
        co_inc      = (co_reg != {CNT_W{1'b1}}) ? co_reg + CNT_W'(1) : co_reg;
        word_ok     = (fc_inc == 4'(aec_pkg::WORD_BYTES)) &&
                      (co_inc >= CNT_W'(aec_pkg::WORD_BYTES));
        pos         = co_inc - CNT_W'(aec_pkg::WORD_BYTES);
        pos_zero    = (pos == '0);
        not_greater = (word <= ext_reg);
        at_window   = (SUM_W'(pos) == SUM_W'(eo_reg) + SUM_W'(wl_reg));
        at_max      = (SUM_W'(pos) == SUM_W'(mcl_reg));
        in_window   = (SUM_W'(pos) <= SUM_W'(wl_reg));
        cut         = word_ok && !pos_zero && !not_greater && (at_window || at_max) &&
                      !(last && in_window);
        tail_len    = cut ? CNT_W'(aec_pkg::WORD_BYTES) : co_inc;

        rb_next  = word;
        fc_next  = fc_inc;
        co_next  = co_inc;
        ext_next = ext_reg;
        eo_next  = eo_reg;
        if (word_ok) begin
            if (pos_zero) begin
                ext_next = word;
                eo_next  = '0;
            end else if (not_greater) begin
                ext_next = word;
                eo_next  = pos;
            end else if (cut) begin
                co_next  = CNT_W'(aec_pkg::WORD_BYTES);
                ext_next = word;
                eo_next  = '0;
            end
        end
        if (last) begin
            rb_next  = '0;
            fc_next  = '0;
            co_next  = '0;
            ext_next = '0;
            eo_next  = '0;
        end

        push.count               = fire ? {cut && last, cut ^ last} : 2'd0;
        push.first.chunk_length  = cut ? 32'(pos) : 32'(tail_len);
        push.first.final_chunk   = !cut;
        push.second.chunk_length = 32'(tail_len);
        push.second.final_chunk  = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            wl_reg     <= aec_pkg::WINDOW_LENGTH_RESET;
            mcl_reg    <= aec_pkg::MAX_CHUNK_LENGTH_RESET;
            rb_reg     <= '0;
            fc_reg     <= '0;
            ext_reg    <= '0;
            eo_reg     <= '0;
            co_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (cfg_we) begin
                case (cfg_index)
                    aec_pkg::REG_WINDOW_LENGTH:    wl_reg  <= cfg_data;
                    aec_pkg::REG_MAX_CHUNK_LENGTH: mcl_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (fire) begin
                rb_reg  <= rb_next;
                fc_reg  <= fc_next;
                ext_reg <= ext_next;
                eo_reg  <= eo_next;
                co_reg  <= co_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

endmodule

// ===== hw/rtl/aec_result_fifo.sv =====
module aec_result_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  aec_pkg::push_t push,
    output logic           push_space,
    output logic           m_valid,
    input  logic           m_ready,
    output aec_pkg::out_t  m_data
);

    aec_pkg::out_t                  mem [aec_pkg::RQ_DEPTH];
    logic [aec_pkg::RQ_PTR_W-1:0]   wr_ptr_reg;
    logic [aec_pkg::RQ_PTR_W-1:0]   rd_ptr_reg;
    logic [aec_pkg::RQ_CNT_W-1:0]   cnt_reg;
    logic                           pop;

    // room for a pair of results from one request
    assign push_space = (cnt_reg <= aec_pkg::RQ_CNT_W'(aec_pkg::RQ_DEPTH - 2));
    assign m_valid    = (cnt_reg != '0);
    assign m_data     = mem[rd_ptr_reg];
    assign pop        = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + aec_pkg::RQ_PTR_W'(push.count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + aec_pkg::RQ_PTR_W'(1);
            end
            cnt_reg <= cnt_reg + aec_pkg::RQ_CNT_W'(push.count)
                               - aec_pkg::RQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + aec_pkg::RQ_PTR_W'(1)] <= push.second;
        end
    end

endmodule

// ===== hw/rtl/aec_checker.sv =====
module aec_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input aec_pkg::out_t m_data
);

    // a pending result holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing pending right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result present after reset");

    // input side open right after reset
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // every chunk carries at least one byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.chunk_length != 32'd0)
        else $error("zero-length chunk");

endmodule

bind asymmetric_extremum_chunker_unit aec_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
